// ===== hdl/trta_pkg.sv =====
package trta_pkg;

    localparam int NUM_SLOTS_DEF  = 64;
    localparam int MAX_REPORT_DEF = 16;
    localparam int ID_W           = 22;
    localparam int TS_W           = 64;
    localparam int CNT_W          = 32;
    localparam int ROWS_CFG_W     = 5;
    localparam int RANK_W         = 4;
    localparam logic [ROWS_CFG_W-1:0] REPORT_ROWS_RESET = 5'd10;

    localparam logic ACT_SWITCH = 1'b0;
    localparam logic ACT_REPORT = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    typedef struct packed {
        logic            action;
        logic            prev_present;
        logic [ID_W-1:0] prev_task_id;
        logic            next_present;
        logic [ID_W-1:0] next_task_id;
        logic [TS_W-1:0] timestamp;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic              status;
        logic              row_valid;
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   task_id;
        logic [TS_W-1:0]   run_total;
        logic              last;
        logic [CNT_W-1:0]  event_count;
        logic [CNT_W-1:0]  switch_count;
    } rsp_t;

endpackage

// ===== hdl/trta_ram.sv =====
module trta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/task_runtime_topk_accounting.sv =====
// Per-task run-time accounting table. A switch beat names the outgoing and
// incoming task and a timestamp; the outgoing task, if running, gets the
// elapsed time added to a saturating total and becomes ranked, and the
// incoming task is marked running (taking a free slot if new; status 1 when
// the table is full). A report beat returns up to report_rows rows, largest
// total first, most recently updated first among equal totals, lower slot
// first on a full tie; an empty table returns one row with row_valid 0.
// Timing: one item at a time, req_ready only while idle. A real switch
// scans the task RAM over all slots, then does read / subtract /
// saturating-add on the total RAM, then the incoming slot update and the
// acknowledge; the read / subtract / add steps are skipped when the
// outgoing task is not running. A report makes one scan of the slot RAMs
// per row through a single compare unit. Other switches and empty reports
// go straight to their result. Every result waits for rsp_ready.
module task_runtime_topk_accounting #(
    parameter int NUM_SLOTS  = trta_pkg::NUM_SLOTS_DEF,
    parameter int MAX_REPORT = trta_pkg::MAX_REPORT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  trta_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output trta_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [trta_pkg::ROWS_CFG_W-1:0] cfg_wdata
);
    import trta_pkg::*;

    localparam int IW   = $clog2(NUM_SLOTS);
    localparam int CW   = $clog2(NUM_SLOTS + 1);
    localparam int ROWW = $clog2(MAX_REPORT + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SSCAN  = 4'd1;
    localparam logic [3:0] ST_ACC1   = 4'd2;
    localparam logic [3:0] ST_ACC2   = 4'd3;
    localparam logic [3:0] ST_ACC3   = 4'd4;
    localparam logic [3:0] ST_NEXT   = 4'd5;
    localparam logic [3:0] ST_ACK    = 4'd6;
    localparam logic [3:0] ST_REMPTY = 4'd7;
    localparam logic [3:0] ST_RSCAN  = 4'd8;
    localparam logic [3:0] ST_REMIT  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [NUM_SLOTS-1:0]  used_reg, used_next;
    logic [NUM_SLOTS-1:0]  running_reg, running_next;
    logic [NUM_SLOTS-1:0]  ranked_reg, ranked_next;
    logic [NUM_SLOTS-1:0]  taken_reg, taken_next;
    logic [CW-1:0]         ranked_cnt_reg, ranked_cnt_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]      seq_reg, seq_next;
    logic [CNT_W-1:0]      events_reg, events_next;
    logic [CNT_W-1:0]      switches_reg, switches_next;
    logic                  prev_found_reg, prev_found_next;
    logic                  next_found_reg, next_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  best_found_reg, best_found_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [ROWW-1:0]       rows_reg, rows_next;
    logic [ROWW-1:0]       row_n_reg, row_n_next;

    // payload (no reset)
    req_t                  item_reg, item_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  status_reg, status_next;
    logic [IW-1:0]         prev_slot_reg, prev_slot_next;
    logic [IW-1:0]         next_slot_reg, next_slot_next;
    logic [IW-1:0]         free_slot_reg, free_slot_next;
    logic [IW-1:0]         best_slot_reg, best_slot_next;
    logic [TS_W-1:0]       best_total_reg, best_total_next;
    logic [CNT_W-1:0]      best_order_reg, best_order_next;
    logic [ID_W-1:0]       best_task_reg, best_task_next;
    logic [TS_W-1:0]       delta_reg, delta_next;
    logic [TS_W-1:0]       base_reg, base_next;

    // RAM ports
    logic [IW-1:0]         raddr;
    logic [ID_W-1:0]       task_rd;
    logic [TS_W-1:0]       start_rd;
    logic [TS_W-1:0]       total_rd;
    logic [CNT_W-1:0]      order_rd;
    logic                  task_we;
    logic                  start_we;
    logic                  total_we;
    logic [TS_W-1:0]       total_wdata;

    logic                  out_free;
    logic [IW-1:0]         proc_idx;
    logic [TS_W:0]         sum_wide;
    logic [ROWS_CFG_W-1:0] rows_clamp;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // slot under compare is the one addressed on the previous cycle
    assign proc_idx = IW'(cnt_reg - CW'(1));
    assign raddr    = (state_reg == ST_ACC1) ? prev_slot_reg :
                      (cnt_reg == CW'(NUM_SLOTS)) ? '0 : cnt_reg[IW-1:0];

    assign sum_wide    = {1'b0, base_reg} + {1'b0, delta_reg};
    assign total_wdata = sum_wide[TS_W] ? '1 : sum_wide[TS_W-1:0];

    trta_ram #(.WIDTH(ID_W), .DEPTH(NUM_SLOTS)) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .waddr (free_slot_reg),
        .wdata (item_reg.next_task_id),
        .raddr (raddr),
        .rdata (task_rd)
    );

    trta_ram #(.WIDTH(TS_W), .DEPTH(NUM_SLOTS)) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (next_found_reg ? next_slot_reg : free_slot_reg),
        .wdata (item_reg.timestamp),
        .raddr (raddr),
        .rdata (start_rd)
    );

    trta_ram #(.WIDTH(TS_W), .DEPTH(NUM_SLOTS)) u_total_ram (
        .clk   (clk),
        .we    (total_we),
        .waddr (prev_slot_reg),
        .wdata (total_wdata),
        .raddr (raddr),
        .rdata (total_rd)
    );

    trta_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_order_ram (
        .clk   (clk),
        .we    (total_we),
        .waddr (prev_slot_reg),
        .wdata (seq_reg),
        .raddr (raddr),
        .rdata (order_rd)
    );

    // clamp the row count: 0 acts as 1, capped at MAX_REPORT
    always_comb
    begin
        rows_clamp = (rows_cfg_reg == '0) ? ROWS_CFG_W'(1) : rows_cfg_reg;
        if (32'(rows_clamp) > 32'(MAX_REPORT))
        begin
            rows_clamp = ROWS_CFG_W'(MAX_REPORT);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        running_next    = running_reg;
        ranked_next     = ranked_reg;
        taken_next      = taken_reg;
        ranked_cnt_next = ranked_cnt_reg;
        cnt_next        = cnt_reg;
        seq_next        = seq_reg;
        events_next     = events_reg;
        switches_next   = switches_reg;
        prev_found_next = prev_found_reg;
        next_found_next = next_found_reg;
        free_found_next = free_found_reg;
        best_found_next = best_found_reg;
        rows_next       = rows_reg;
        row_n_next      = row_n_reg;
        item_next       = item_reg;
        rsp_next        = rsp_reg;
        status_next     = status_reg;
        prev_slot_next  = prev_slot_reg;
        next_slot_next  = next_slot_reg;
        free_slot_next  = free_slot_reg;
        best_slot_next  = best_slot_reg;
        best_total_next = best_total_reg;
        best_order_next = best_order_reg;
        best_task_next  = best_task_reg;
        delta_next      = delta_reg;
        base_next       = base_reg;
        task_we         = 1'b0;
        start_we        = 1'b0;
        total_we        = 1'b0;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    cnt_next  = '0;
                    if (req.action == ACT_REPORT)
                    begin
                        if (ranked_cnt_reg == '0)
                        begin
                            state_next = ST_REMPTY;
                        end
                        else
                        begin
                            if (32'(ranked_cnt_reg) < 32'(rows_clamp))
                            begin
                                rows_next = ROWW'(ranked_cnt_reg);
                            end
                            else
                            begin
                                rows_next = ROWW'(rows_clamp);
                            end
                            row_n_next      = '0;
                            taken_next      = '0;
                            best_found_next = 1'b0;
                            state_next      = ST_RSCAN;
                        end
                    end
                    else
                    begin
                        events_next = events_reg + CNT_W'(1);
                        if (req.prev_present && req.next_present &&
                            req.prev_task_id != req.next_task_id)
                        begin
                            prev_found_next = 1'b0;
                            next_found_next = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = ST_SSCAN;
                        end
                        else
                        begin
                            status_next = 1'b0;
                            state_next  = ST_ACK;
                        end
                    end
                end
            end

            ST_SSCAN:
            begin
                if (cnt_reg != CW'(NUM_SLOTS))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (cnt_reg != '0)
                begin
                    if (used_reg[proc_idx])
                    begin
                        if (!prev_found_reg && task_rd == item_reg.prev_task_id)
                        begin
                            prev_found_next = 1'b1;
                            prev_slot_next  = proc_idx;
                        end
                        if (!next_found_reg && task_rd == item_reg.next_task_id)
                        begin
                            next_found_next = 1'b1;
                            next_slot_next  = proc_idx;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = proc_idx;
                    end
                end
                if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    state_next = ST_ACC1;
                end
            end

            ST_ACC1:
            begin
                // raddr points at the outgoing slot here
                if (prev_found_reg && running_reg[prev_slot_reg])
                begin
                    state_next = ST_ACC2;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end

            ST_ACC2:
            begin
                delta_next = item_reg.timestamp - start_rd;
                base_next  = ranked_reg[prev_slot_reg] ? total_rd : '0;
                state_next = ST_ACC3;
            end

            ST_ACC3:
            begin
                total_we                    = 1'b1;
                running_next[prev_slot_reg] = 1'b0;
                ranked_next[prev_slot_reg]  = 1'b1;
                seq_next                    = seq_reg + CNT_W'(1);
                if (!ranked_reg[prev_slot_reg])
                begin
                    ranked_cnt_next = ranked_cnt_reg + CW'(1);
                end
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                status_next = 1'b0;
                if (next_found_reg)
                begin
                    running_next[next_slot_reg] = 1'b1;
                    start_we                    = 1'b1;
                end
                else if (free_found_reg)
                begin
                    used_next[free_slot_reg]    = 1'b1;
                    ranked_next[free_slot_reg]  = 1'b0;
                    running_next[free_slot_reg] = 1'b1;
                    task_we                     = 1'b1;
                    start_we                    = 1'b1;
                end
                else
                begin
                    status_next = 1'b1;
                end
                switches_next = switches_reg + CNT_W'(1);
                state_next    = ST_ACK;
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.result_kind  = KIND_ACK;
                    rsp_next.status       = status_reg;
                    rsp_next.row_valid    = 1'b0;
                    rsp_next.rank         = '0;
                    rsp_next.task_id      = '0;
                    rsp_next.run_total    = '0;
                    rsp_next.last         = 1'b1;
                    rsp_next.event_count  = events_reg;
                    rsp_next.switch_count = switches_reg;
                    state_next            = ST_IDLE;
                end
            end

            ST_REMPTY:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.result_kind  = KIND_ROW;
                    rsp_next.status       = 1'b0;
                    rsp_next.row_valid    = 1'b0;
                    rsp_next.rank         = '0;
                    rsp_next.task_id      = '0;
                    rsp_next.run_total    = '0;
                    rsp_next.last         = 1'b1;
                    rsp_next.event_count  = events_reg;
                    rsp_next.switch_count = switches_reg;
                    state_next            = ST_IDLE;
                end
            end

            ST_RSCAN:
            begin
                if (cnt_reg != CW'(NUM_SLOTS))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (cnt_reg != '0 && ranked_reg[proc_idx] && !taken_reg[proc_idx])
                begin
                    if (!best_found_reg || total_rd > best_total_reg ||
                        (total_rd == best_total_reg && order_rd > best_order_reg))
                    begin
                        best_found_next = 1'b1;
                        best_slot_next  = proc_idx;
                        best_total_next = total_rd;
                        best_order_next = order_rd;
                        best_task_next  = task_rd;
                    end
                end
                if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    state_next = ST_REMIT;
                end
            end

            ST_REMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.result_kind      = KIND_ROW;
                    rsp_next.status           = 1'b0;
                    rsp_next.row_valid        = 1'b1;
                    rsp_next.rank             = RANK_W'(row_n_reg);
                    rsp_next.task_id          = best_task_reg;
                    rsp_next.run_total        = best_total_reg;
                    rsp_next.event_count      = events_reg;
                    rsp_next.switch_count     = switches_reg;
                    taken_next[best_slot_reg] = 1'b1;
                    if (row_n_reg + ROWW'(1) == rows_reg)
                    begin
                        rsp_next.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        rsp_next.last   = 1'b0;
                        row_n_next      = row_n_reg + ROWW'(1);
                        cnt_next        = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_RSCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rows_cfg_reg   <= REPORT_ROWS_RESET;
            used_reg       <= '0;
            running_reg    <= '0;
            ranked_reg     <= '0;
            taken_reg      <= '0;
            ranked_cnt_reg <= '0;
            cnt_reg        <= '0;
            seq_reg        <= '0;
            events_reg     <= '0;
            switches_reg   <= '0;
            prev_found_reg <= 1'b0;
            next_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rows_reg       <= '0;
            row_n_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                rows_cfg_reg <= cfg_wdata;
            end
            used_reg       <= used_next;
            running_reg    <= running_next;
            ranked_reg     <= ranked_next;
            taken_reg      <= taken_next;
            ranked_cnt_reg <= ranked_cnt_next;
            cnt_reg        <= cnt_next;
            seq_reg        <= seq_next;
            events_reg     <= events_next;
            switches_reg   <= switches_next;
            prev_found_reg <= prev_found_next;
            next_found_reg <= next_found_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            rows_reg       <= rows_next;
            row_n_reg      <= row_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        rsp_reg        <= rsp_next;
        status_reg     <= status_next;
        prev_slot_reg  <= prev_slot_next;
        next_slot_reg  <= next_slot_next;
        free_slot_reg  <= free_slot_next;
        best_slot_reg  <= best_slot_next;
        best_total_reg <= best_total_next;
        best_order_reg <= best_order_next;
        best_task_reg  <= best_task_next;
        delta_reg      <= delta_next;
        base_reg       <= base_next;
    end

endmodule

// ===== hdl/trta_checker.sv =====
module trta_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input trta_pkg::rsp_t rsp
);
    import trta_pkg::*;

    // a result beat holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // no new request while a report is still mid-way
    a_no_req_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !req_ready)
        else $error("request taken during a report");

    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == KIND_ACK |-> rsp.last && !rsp.row_valid)
        else $error("bad switch acknowledge");

    a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == KIND_ROW && !rsp.row_valid
        |-> rsp.last && rsp.rank == '0 && rsp.task_id == '0 && !rsp.status)
        else $error("bad empty report row");

endmodule

bind task_runtime_topk_accounting trta_checker u_trta_checker (.*);

// ===== bench/tb_task_runtime_topk_accounting.sv =====
module tb_task_runtime_topk_accounting;
    timeunit 1ns;
    timeprecision 1ps;

    import trta_pkg::*;

    localparam int SLOTS     = NUM_SLOTS_DEF;
    localparam int TOP_ROWS  = MAX_REPORT_DEF;
    // slowest item: full report, 16 scans of the slot RAMs
    localparam int DRAIN_CYC = (SLOTS + 2) * TOP_ROWS + 20;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_we;
    logic [ROWS_CFG_W-1:0] cfg_wdata;

    task_runtime_topk_accounting dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the accounting table
    // ---------------------------------------------------------------
    logic [ROWS_CFG_W-1:0] rows_cfg;
    logic                  tbl_used    [SLOTS];
    logic [ID_W-1:0]       tbl_task    [SLOTS];
    logic                  tbl_running [SLOTS];
    logic                  tbl_ranked  [SLOTS];
    logic [TS_W-1:0]       tbl_start   [SLOTS];
    logic [TS_W-1:0]       tbl_total   [SLOTS];
    logic [CNT_W-1:0]      tbl_order   [SLOTS];
    logic [CNT_W-1:0]      order_seq;
    logic [CNT_W-1:0]      n_events;
    logic [CNT_W-1:0]      n_switches;

    req_t pending_reqs[$];     // items waiting for the driver
    rsp_t expected_rows[$];    // predicted results, oldest first
    int   n_errors;
    bit   stim_done;

    // small id pool keeps tasks recurring; a few far ids stress the upper bits
    logic [ID_W-1:0] id_pool[24];

    function automatic int lookup_task(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_task[i] == id)
                return i;
        return -1;
    endfunction

    function automatic rsp_t blank_rsp();
        rsp_t r;
        r = '0;
        r.event_count  = n_events;
        r.switch_count = n_switches;
        return r;
    endfunction

    // Apply one accepted beat to the shadow table, queue its results.
    task automatic account_beat(req_t b);
        int   s;
        int   best;
        int   rows;
        int   n;
        bit   taken[SLOTS];
        logic [TS_W-1:0] base;
        logic [TS_W:0]   sum;
        rsp_t r;
        if (b.action == ACT_SWITCH) begin
            r = '0;
            n_events++;
            if (b.prev_present && b.next_present && b.prev_task_id != b.next_task_id) begin
                s = lookup_task(b.prev_task_id);
                if (s >= 0 && tbl_running[s]) begin
                    base = tbl_ranked[s] ? tbl_total[s] : '0;
                    sum  = {1'b0, base} + {1'b0, b.timestamp - tbl_start[s]};
                    tbl_total[s]   = sum[TS_W] ? '1 : sum[TS_W-1:0];
                    tbl_ranked[s]  = 1'b1;
                    tbl_running[s] = 1'b0;
                    tbl_order[s]   = order_seq;
                    order_seq++;
                end
                s = lookup_task(b.next_task_id);
                if (s < 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_used[i]) begin
                            s = i;
                            break;
                        end
                    if (s >= 0) begin
                        tbl_used[s]   = 1'b1;
                        tbl_task[s]   = b.next_task_id;
                        tbl_ranked[s] = 1'b0;
                    end
                end
                if (s >= 0) begin
                    tbl_running[s] = 1'b1;
                    tbl_start[s]   = b.timestamp;
                end else begin
                    r.status = 1'b1;
                end
                n_switches++;
            end
            r.result_kind  = KIND_ACK;
            r.last         = 1'b1;
            r.event_count  = n_events;
            r.switch_count = n_switches;
            expected_rows.push_back(r);
        end else begin
            rows = (rows_cfg == 0) ? 1 : (rows_cfg > TOP_ROWS ? TOP_ROWS : rows_cfg);
            foreach (taken[i]) taken[i] = 1'b0;
            n = 0;
            while (n < rows) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_used[i] || !tbl_ranked[i] || taken[i])
                        continue;
                    if (best < 0 || tbl_total[i] > tbl_total[best] ||
                        (tbl_total[i] == tbl_total[best] && tbl_order[i] > tbl_order[best]))
                        best = i;
                end
                if (best < 0)
                    break;
                taken[best] = 1'b1;
                r = blank_rsp();
                r.result_kind = KIND_ROW;
                r.row_valid   = 1'b1;
                r.rank        = RANK_W'(n);
                r.task_id     = tbl_task[best];
                r.run_total   = tbl_total[best];
                expected_rows.push_back(r);
                n++;
            end
            if (n == 0) begin
                r = blank_rsp();
                r.result_kind = KIND_ROW;
                r.last        = 1'b1;
                expected_rows.push_back(r);
            end else begin
                expected_rows[$].last = 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, reset, watchdog
    // ---------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: bursts of beats with random gaps
    // ---------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // beat taken this edge: predict from the payload just accepted
            if (req_valid && req_ready)
                account_beat(req);
            if (!req_valid || req_ready) begin
                if (gap_left > 0) begin
                    req_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end else if (pending_reqs.size() > 0) begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= int'($urandom_range(1, 8));
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                      int'($urandom_range(1, 40));
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: receiver stall pattern plus checks
    // ---------------------------------------------------------------
    int stall_phase;
    int stall_mode;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ready   <= 1'b0;
            stall_phase <= 0;
            stall_mode  <= 0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected result beat kind=%0d", rsp.result_kind);
                    n_errors++;
                end else begin
                    rsp_t e;
                    e = expected_rows.pop_front();
                    if (rsp.result_kind !== e.result_kind) begin
                        $error("result_kind exp %0d got %0d", e.result_kind, rsp.result_kind);
                        n_errors++;
                    end
                    if (rsp.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        n_errors++;
                    end
                    if (rsp.row_valid !== e.row_valid) begin
                        $error("row_valid exp %0d got %0d", e.row_valid, rsp.row_valid);
                        n_errors++;
                    end
                    if (rsp.rank !== e.rank) begin
                        $error("rank exp %0d got %0d", e.rank, rsp.rank);
                        n_errors++;
                    end
                    if (rsp.task_id !== e.task_id) begin
                        $error("task_id exp %0h got %0h", e.task_id, rsp.task_id);
                        n_errors++;
                    end
                    if (rsp.run_total !== e.run_total) begin
                        $error("run_total exp %0h got %0h", e.run_total, rsp.run_total);
                        n_errors++;
                    end
                    if (rsp.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, rsp.last);
                        n_errors++;
                    end
                    if (rsp.event_count !== e.event_count) begin
                        $error("event_count exp %0d got %0d", e.event_count, rsp.event_count);
                        n_errors++;
                    end
                    if (rsp.switch_count !== e.switch_count) begin
                        $error("switch_count exp %0d got %0d", e.switch_count, rsp.switch_count);
                        n_errors++;
                    end
                end
            end
            // pattern: mode 0 always ready, 1 every other cycle, 2 random, 3 long stalls
            stall_phase <= stall_phase + 1;
            if (stall_phase % 200 == 199)
                stall_mode <= int'($urandom_range(0, 3));
            case (stall_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= stall_phase[0];
                2:       rsp_ready <= 1'($urandom_range(0, 1));
                default: rsp_ready <= (stall_phase % 24) < 4;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic req_t mk_switch(bit pp, logic [ID_W-1:0] p, bit np,
                                       logic [ID_W-1:0] nx, logic [TS_W-1:0] ts);
        req_t b;
        b = '0;
        b.action       = ACT_SWITCH;
        b.prev_present = pp;
        b.prev_task_id = p;
        b.next_present = np;
        b.next_task_id = nx;
        b.timestamp    = ts;
        return b;
    endfunction

    function automatic req_t mk_report();
        req_t b;
        b = '0;
        b.action       = ACT_REPORT;
        // noise in ignored fields
        b.prev_present = 1'($urandom_range(0, 1));
        b.prev_task_id = ID_W'($urandom);
        b.next_present = 1'($urandom_range(0, 1));
        b.next_task_id = ID_W'($urandom);
        b.timestamp    = {$urandom, $urandom};
        return b;
    endfunction

    // Wait for every expected beat, then let the block settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rows.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_rows(logic [ROWS_CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_cfg = v;
    endtask

    // Random phase: chains of well-formed switches where the outgoing
    // task is the one currently running, plus noise and reports.
    task automatic random_phase(int count, int id_span);
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] nx;
        logic [TS_W-1:0] ts;
        int k;
        cur = id_pool[0];
        ts  = {$urandom, $urandom};
        for (int i = 0; i < count; i++) begin
            k = int'($urandom_range(0, 99));
            nx = id_pool[$urandom_range(0, id_span - 1)];
            if (k < 65) begin
                case ($urandom_range(0, 9))
                    0:       ts = ts + {$urandom, $urandom};          // huge delta, wraps
                    1:       ts = ts;                                  // zero delta
                    default: ts = ts + TS_W'($urandom_range(1, 5000));
                endcase
                pending_reqs.push_back(mk_switch(1'b1, cur, 1'b1, nx, ts));
                if (nx != cur)
                    cur = nx;
            end else if (k < 80) begin
                pending_reqs.push_back(mk_report());
            end else begin
                pending_reqs.push_back(mk_switch(1'($urandom_range(0, 1)), ID_W'($urandom),
                                                 1'($urandom_range(0, 1)), ID_W'($urandom),
                                                 {$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        n_errors   = 0;
        stim_done  = 0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rows_cfg   = REPORT_ROWS_RESET;
        order_seq  = '0;
        n_events   = '0;
        n_switches = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i]    = 1'b0;
            tbl_running[i] = 1'b0;
            tbl_ranked[i]  = 1'b0;
            tbl_task[i]    = '0;
            tbl_start[i]   = '0;
            tbl_total[i]   = '0;
            tbl_order[i]   = '0;
        end
        for (int i = 0; i < 24; i++)
            id_pool[i] = (i < 20) ? ID_W'(i + 1) : ID_W'($urandom);
        id_pool[20] = '1;
        id_pool[21] = '0;

        @(posedge rst_n);
        @(posedge clk);

        // --- directed ---
        pending_reqs.push_back(mk_report());                          // empty report
        pending_reqs.push_back(mk_switch(1'b0, 22'd5, 1'b1, 22'd6, 64'd100)); // outgoing absent
        pending_reqs.push_back(mk_switch(1'b1, '1, 1'b0, 22'd6, 64'd100));    // incoming absent
        pending_reqs.push_back(mk_switch(1'b1, 22'd7, 1'b1, 22'd7, 64'd100)); // same id
        pending_reqs.push_back(mk_switch(1'b1, '1, 1'b1, '0, 64'd10));       // outgoing unknown
        pending_reqs.push_back(mk_switch(1'b1, '0, 1'b1, '1, 64'd30));       // 0 ranked, total 20
        pending_reqs.push_back(mk_switch(1'b1, '1, 1'b1, 22'h2AAAAA, 64'd5)); // wraps modulo 2^64
        pending_reqs.push_back(mk_switch(1'b1, '1, 1'b1, 22'h155555, 64'd9)); // '1 not running
        pending_reqs.push_back(mk_switch(1'b1, 22'h2AAAAA, 1'b1, '0, '1));   // huge total
        pending_reqs.push_back(mk_switch(1'b1, '0, 1'b1, 22'h2AAAAA, 64'd40)); // 0 wraps too
        pending_reqs.push_back(mk_switch(1'b1, 22'h2AAAAA, 1'b1, 22'h155555,
                                         64'd60));                           // saturates
        pending_reqs.push_back(mk_switch(1'b1, 22'h155555, 1'b1, 22'd3,
                                         64'd80));                           // equal-ish totals
        pending_reqs.push_back(mk_switch(1'b1, 22'd3, 1'b1, 22'd4, 64'd80)); // zero delta
        pending_reqs.push_back(mk_report());
        drain();

        // report_rows 0 acts as one row
        write_rows(5'd0);
        pending_reqs.push_back(mk_report());
        drain();

        // fill the table until the incoming task is dropped
        write_rows(5'd31);
        for (int i = 0; i < SLOTS + 3; i++)
            pending_reqs.push_back(mk_switch(1'b1, ID_W'(1000 + i), 1'b1, ID_W'(1001 + i),
                                             TS_W'(i * 7 + (i % 5))));
        pending_reqs.push_back(mk_report());
        pending_reqs.push_back(mk_switch(1'b1, 22'd2000, 1'b1, 22'd1001,
                                         64'd900));                          // known task fits
        pending_reqs.push_back(mk_report());
        drain();

        // --- random: reset is once only, so a full table dominates; keep ids in it ---
        for (int i = 0; i < 24; i++)
            id_pool[i] = ID_W'(1001 + $urandom_range(0, SLOTS - 1));
        id_pool[0] = ID_W'(1001);
        write_rows(5'd16);
        random_phase(60, 24);
        drain();
        write_rows(5'd1);
        random_phase(45, 24);
        drain();
        write_rows(REPORT_ROWS_RESET);
        random_phase(50, 24);
        drain();
        write_rows(ROWS_CFG_W'($urandom_range(2, 15)));
        random_phase(40, 24);
        drain();

        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/trta_pkg.sv
hdl/trta_ram.sv
hdl/task_runtime_topk_accounting.sv
hdl/trta_checker.sv
bench/tb_task_runtime_topk_accounting.sv
